### hdl/jsu_pkg.sv
package jsu_pkg;

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // input modes
  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_EOT  = 1'b1;

  // one decoded step: one to three results that the back part plays out in order
  typedef struct packed {
    logic [1:0] cnt;
    logic [1:0] kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } cmd_t;

endpackage

### hdl/json_string_unescape_top.sv
// channel  | handshake       | fields
// input    | push / full     | mode, data_byte
// result   | pop / empty     | out_byte, kind, last
//
// One input byte is taken per cycle while the request queue has room.
// Results leave one per pop; a \u escape gives up to three results,
// played out in order by the back serializer.
// Reset (rst, synchronous) returns the decoder to waiting for a quote
// and empties the queue. A stalled result side fills the queue of
// QDEPTH requests, after which full rises.
module json_string_unescape_top #(
  parameter int QDEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       mode,
  input  logic [7:0] data_byte,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic       last
);

  logic          q_push, q_pop;
  jsu_pkg::cmd_t q_wr_cmd, q_rd_cmd;

  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .q_full    (full),
    .mode      (mode),
    .data_byte (data_byte),
    .q_push    (q_push),
    .q_cmd     (q_wr_cmd)
  );

  jsu_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wr_cmd),
    .full    (full),
    .rd      (q_pop),
    .rd_data (q_rd_cmd),
    .empty   (empty)
  );

  jsu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (q_rd_cmd),
    .q_empty  (empty),
    .q_pop    (q_pop),
    .pop      (pop),
    .out_byte (out_byte),
    .kind     (kind),
    .last     (last)
  );

  // end and error results stand alone
  a_ctrl_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != jsu_pkg::KIND_BYTE) |-> last)
    else $error("end or error result not marked last");

  // end and error results carry a zero byte
  a_ctrl_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != jsu_pkg::KIND_BYTE) |-> out_byte == 8'h00)
    else $error("end or error result carries a byte");

  // a multi-byte sequence keeps the result side non-empty
  a_burst_hold: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last) |=> !empty)
    else $error("result sequence broken before its last byte");

endmodule

### hdl/jsu_front.sv
module jsu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                q_full,
  input  logic                mode,
  input  logic [7:0]          data_byte,
  output logic                q_push,
  output jsu_pkg::cmd_t       q_cmd
);

  typedef enum logic [3:0] {
    PH_WAIT = 4'b0001,
    PH_TEXT = 4'b0010,
    PH_ESC  = 4'b0100,
    PH_HEX  = 4'b1000
  } phase_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] C_2B_LEAD = 8'hC0;
  localparam logic [7:0] C_3B_LEAD = 8'hE0;
  localparam logic [7:0] C_CONT    = 8'h80;

  phase_t      phase, phase_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [11:0] code_accum, code_accum_next;
  logic        accept;
  logic        emit;
  logic [4:0]  hex_d;
  logic [15:0] code;

  // decode one hex digit: {valid, value}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  assign accept = push && !q_full;
  assign hex_d  = hex_value(data_byte);
  assign code   = {code_accum, hex_d[3:0]};

  // classify the byte and build the result request
  always_comb begin
    phase_next      = phase;
    hex_count_next  = hex_count;
    code_accum_next = code_accum;
    emit            = 1'b0;
    q_cmd.cnt       = 2'd1;
    q_cmd.kind      = jsu_pkg::KIND_BYTE;
    q_cmd.b0        = 8'h00;
    q_cmd.b1        = 8'h00;
    q_cmd.b2        = 8'h00;
    if (mode == jsu_pkg::MODE_EOT) begin
      phase_next      = PH_WAIT;
      hex_count_next  = 2'd0;
      code_accum_next = 12'd0;
      emit            = 1'b1;
      q_cmd.kind      = jsu_pkg::KIND_ERR;
    end else begin
      unique case (phase)
        PH_WAIT: begin
          if (data_byte == CH_QUOTE) begin
            phase_next = PH_TEXT;
          end else begin
            emit       = 1'b1;
            q_cmd.kind = jsu_pkg::KIND_ERR;
          end
        end
        PH_TEXT: begin
          if (data_byte == CH_QUOTE) begin
            phase_next = PH_WAIT;
            emit       = 1'b1;
            q_cmd.kind = jsu_pkg::KIND_END;
          end else if (data_byte == CH_BSL) begin
            phase_next = PH_ESC;
          end else begin
            emit     = 1'b1;
            q_cmd.b0 = data_byte;
          end
        end
        PH_ESC: begin
          emit       = 1'b1;
          phase_next = PH_TEXT;
          unique case (data_byte)
            8'h22: q_cmd.b0 = 8'h22;
            8'h5C: q_cmd.b0 = 8'h5C;
            8'h2F: q_cmd.b0 = 8'h2F;
            8'h62: q_cmd.b0 = 8'h08;
            8'h66: q_cmd.b0 = 8'h0C;
            8'h6E: q_cmd.b0 = 8'h0A;
            8'h72: q_cmd.b0 = 8'h0D;
            8'h74: q_cmd.b0 = 8'h09;
            8'h75: begin
              emit            = 1'b0;
              phase_next      = PH_HEX;
              hex_count_next  = 2'd0;
              code_accum_next = 12'd0;
            end
            default: begin
              phase_next      = PH_WAIT;
              hex_count_next  = 2'd0;
              code_accum_next = 12'd0;
              q_cmd.kind      = jsu_pkg::KIND_ERR;
            end
          endcase
        end
        PH_HEX: begin
          if (!hex_d[4]) begin
            phase_next      = PH_WAIT;
            hex_count_next  = 2'd0;
            code_accum_next = 12'd0;
            emit            = 1'b1;
            q_cmd.kind      = jsu_pkg::KIND_ERR;
          end else if (hex_count != 2'd3) begin
            code_accum_next = {code_accum[7:0], hex_d[3:0]};
            hex_count_next  = hex_count + 2'd1;
          end else begin
            phase_next      = PH_TEXT;
            hex_count_next  = 2'd0;
            code_accum_next = 12'd0;
            emit            = 1'b1;
            // encode the code point as UTF-8
            if (code[15:7] == 9'd0) begin
              q_cmd.b0 = code[7:0];
            end else if (code[15:11] == 5'd0) begin
              q_cmd.cnt = 2'd2;
              q_cmd.b0  = C_2B_LEAD | {3'b000, code[10:6]};
              q_cmd.b1  = C_CONT | {2'b00, code[5:0]};
            end else begin
              q_cmd.cnt = 2'd3;
              q_cmd.b0  = C_3B_LEAD | {4'h0, code[15:12]};
              q_cmd.b1  = C_CONT | {2'b00, code[11:6]};
              q_cmd.b2  = C_CONT | {2'b00, code[5:0]};
            end
          end
        end
        default: begin
          phase_next      = PH_WAIT;
          hex_count_next  = 2'd0;
          code_accum_next = 12'd0;
        end
      endcase
    end
  end

  assign q_push = accept && emit;

  // advance the decoder state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_WAIT;
      hex_count  <= 2'd0;
      code_accum <= 12'd0;
    end else if (accept) begin
      phase      <= phase_next;
      hex_count  <= hex_count_next;
      code_accum <= code_accum_next;
    end
  end

endmodule

### hdl/jsu_queue.sv
module jsu_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  jsu_pkg::cmd_t  wr_data,
  output logic           full,
  input  logic           rd,
  output jsu_pkg::cmd_t  rd_data,
  output logic           empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  jsu_pkg::cmd_t   mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr, do_rd;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  // store requests
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### hdl/jsu_back.sv
module jsu_back (
  input  logic           clk,
  input  logic           rst,
  input  jsu_pkg::cmd_t  cmd,
  input  logic           q_empty,
  output logic           q_pop,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic [1:0]     kind,
  output logic           last
);

  logic [1:0] idx;
  logic       take;

  assign take = pop && !q_empty;
  assign kind = cmd.kind;
  assign last = (idx == cmd.cnt - 2'd1);

  // select the byte of the current request
  always_comb begin
    unique case (idx)
      2'd0:    out_byte = cmd.b0;
      2'd1:    out_byte = cmd.b1;
      default: out_byte = cmd.b2;
    endcase
  end

  assign q_pop = take && last;

  // step through the bytes of one request, drop it after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (take) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule
